// ----- rtl/rsq_pkg.sv -----
// Shared widths, codes and control types for the rectangle sum query block.
package rsq_pkg;

    localparam int COORD_W   = 7;
    localparam int VAL_W     = 30;
    localparam int SUM_W     = 42;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 48;

    localparam int ROW_LSB    = 0;
    localparam int COL_LSB    = ROW_LSB + COORD_W;
    localparam int VALUE_LSB  = COL_LSB + COORD_W;
    localparam int TOP_LSB    = VALUE_LSB + VAL_W;
    localparam int LEFT_LSB   = TOP_LSB + COORD_W;
    localparam int BOTTOM_LSB = LEFT_LSB + COORD_W;
    localparam int RIGHT_LSB  = BOTTOM_LSB + COORD_W;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [VAL_W-1:0]   val_t;
    typedef logic [SUM_W-1:0]   sum_t;

    typedef struct packed {
        logic clear;
        logic add;
    } acc_ctl_t;

endpackage

// ----- rtl/rsq_cell_mem.sv -----
// Grid cell storage: one write port, one registered read port.
module rsq_cell_mem #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  rsq_pkg::val_t       wr_data,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output rsq_pkg::val_t       rd_data
);

    rsq_pkg::val_t mem [DEPTH];
    rsq_pkg::val_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/rsq_accum.sv -----
// Saturating sum accumulator shared by every cell read of a query.
module rsq_accum (
    input  logic               aclk,
    input  logic               aresetn,
    input  rsq_pkg::acc_ctl_t  ctl,
    input  rsq_pkg::val_t      add_data,
    output rsq_pkg::sum_t      acc
);

    rsq_pkg::sum_t            acc_reg;
    rsq_pkg::sum_t            acc_next;
    logic [rsq_pkg::SUM_W:0]  add_full;

    always_comb begin
        add_full = {1'b0, acc_reg} + (rsq_pkg::SUM_W + 1)'(add_data);
        acc_next = acc_reg;
        if (ctl.clear) begin
            acc_next = '0;
        end else if (ctl.add) begin
            acc_next = add_full[rsq_pkg::SUM_W] ? '1 : add_full[rsq_pkg::SUM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// ----- rtl/rsq_ctrl.sv -----
// Sequencer: grid clear after reset, cell loads and the rectangle walk.
module rsq_ctrl #(
    parameter int MAX_DIM = 64,
    parameter int DEPTH   = 4096,
    parameter int ADDR_W  = 12
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                mode,
    input  rsq_pkg::coord_t     row,
    input  rsq_pkg::coord_t     col,
    input  rsq_pkg::val_t       value,
    input  rsq_pkg::coord_t     top,
    input  rsq_pkg::coord_t     left,
    input  rsq_pkg::coord_t     bottom,
    input  rsq_pkg::coord_t     right,
    input  logic                out_full,
    output logic                done,
    output logic                wr_en,
    output logic [ADDR_W-1:0]   wr_addr,
    output rsq_pkg::val_t       wr_data,
    output logic                rd_en,
    output logic [ADDR_W-1:0]   rd_addr,
    output rsq_pkg::acc_ctl_t   acc_ctl
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CW    = (DIM_W > rsq_pkg::COORD_W) ? DIM_W : rsq_pkg::COORD_W;

    localparam logic [CW-1:0]     ONE_C   = CW'(1);
    localparam logic [CW-1:0]     DIM_C   = CW'(MAX_DIM);
    localparam logic [ADDR_W-1:0] DIM_A   = ADDR_W'(MAX_DIM);
    localparam logic [ADDR_W-1:0] LAST_A  = ADDR_W'(DEPTH - 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_WRITE = 3'd2;
    localparam logic [2:0] ST_WALK  = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [ADDR_W-1:0]   ld_addr_reg, ld_addr_next;
    rsq_pkg::val_t       ld_val_reg, ld_val_next;
    logic [CW-1:0]       row_reg, row_next;
    logic [CW-1:0]       col_reg, col_next;
    logic [CW-1:0]       r1_reg, r1_next;
    logic [CW-1:0]       c0_reg, c0_next;
    logic [CW-1:0]       c1_reg, c1_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic                rd_valid_reg;

    logic [CW-1:0]       row_x, col_x, top_x, left_x, bottom_x, right_x;
    logic [CW-1:0]       r0_c, r1_c, c0_c, c1_c;
    logic                load_ok, query_empty, accept;

    always_comb begin
        row_x    = CW'(row);
        col_x    = CW'(col);
        top_x    = CW'(top);
        left_x   = CW'(left);
        bottom_x = CW'(bottom);
        right_x  = CW'(right);
        r0_c     = (top_x == '0) ? ONE_C : top_x;
        c0_c     = (left_x == '0) ? ONE_C : left_x;
        r1_c     = (bottom_x > DIM_C) ? DIM_C : bottom_x;
        c1_c     = (right_x > DIM_C) ? DIM_C : right_x;
        load_ok  = (row_x != '0) && (row_x <= DIM_C) && (col_x != '0) && (col_x <= DIM_C);
        query_empty = (top > bottom) || (left > right) || (r0_c > r1_c) || (c0_c > c1_c);
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        ld_addr_next  = ld_addr_reg;
        ld_val_next   = ld_val_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        r1_next       = r1_reg;
        c0_next       = c0_reg;
        c1_next       = c1_reg;
        base_next     = base_reg;
        done          = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = clr_addr_reg;
        wr_data       = '0;
        rd_en         = 1'b0;
        rd_addr       = base_reg + ADDR_W'(col_reg - ONE_C);
        acc_ctl.clear = 1'b0;
        acc_ctl.add   = rd_valid_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                wr_en = 1'b1;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == LAST_A) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (mode == rsq_pkg::MODE_LOAD) begin
                        ld_addr_next = ADDR_W'(row_x - ONE_C) * DIM_A
                                     + ADDR_W'(col_x - ONE_C);
                        ld_val_next  = value;
                        if (load_ok) begin
                            state_next = ST_WRITE;
                        end
                    end else begin
                        acc_ctl.clear = 1'b1;
                        row_next  = r0_c;
                        col_next  = c0_c;
                        r1_next   = r1_c;
                        c0_next   = c0_c;
                        c1_next   = c1_c;
                        base_next = ADDR_W'(r0_c - ONE_C) * DIM_A;
                        state_next = query_empty ? ST_DONE : ST_WALK;
                    end
                end
            end
            ST_WRITE: begin
                wr_en   = 1'b1;
                wr_addr = ld_addr_reg;
                wr_data = ld_val_reg;
                state_next = ST_IDLE;
            end
            ST_WALK: begin
                rd_en = 1'b1;
                if (col_reg == c1_reg) begin
                    if (row_reg == r1_reg) begin
                        state_next = ST_DRAIN;
                    end else begin
                        row_next  = row_reg + ONE_C;
                        col_next  = c0_reg;
                        base_next = base_reg + DIM_A;
                    end
                end else begin
                    col_next = col_reg + ONE_C;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!out_full) begin
                    done = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            rd_valid_reg <= (state_reg == ST_WALK);
        end
    end

    always_ff @(posedge aclk) begin
        ld_addr_reg <= ld_addr_next;
        ld_val_reg  <= ld_val_next;
        row_reg     <= row_next;
        col_reg     <= col_next;
        r1_reg      <= r1_next;
        c0_reg      <= c0_next;
        c1_reg      <= c1_next;
        base_reg    <= base_next;
    end

endmodule

// ----- rtl/rectangle_sum_query.sv -----
// Top level of the rectangle sum query block: stream ports and result register.
//
// The block holds a MAX_DIM x MAX_DIM grid of 30-bit cells, rows and columns
// numbered from 1. After reset it clears every cell of the grid, one cell per
// cycle, and accepts no beat meanwhile. A load beat (tuser 0) writes one cell;
// out-of-grid loads are dropped. A query beat (tuser 1) walks the clipped
// rectangle one cell per cycle through the single memory read port and the
// shared saturating adder; an empty rectangle returns zero. Sums saturate at
// 2^42 - 1. The next beat is taken while a result still waits on the master
// side.
module rectangle_sum_query #(
    parameter int MAX_DIM = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // row, col, value, top, left, bottom, right
    input  logic [rsq_pkg::S_TDATA_W-1:0]     s_tdata,
    // mode
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // rect_sum, zero padded
    output logic [rsq_pkg::M_TDATA_W-1:0]     m_tdata
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);

    logic                 wr_en, rd_en, done, out_full;
    logic [ADDR_W-1:0]    wr_addr, rd_addr;
    rsq_pkg::val_t        wr_data, rd_data;
    rsq_pkg::acc_ctl_t    acc_ctl;
    rsq_pkg::sum_t        acc;
    logic                 m_tvalid_reg;
    rsq_pkg::sum_t        sum_reg;

    assign out_full = m_tvalid_reg && !m_tready;

    rsq_ctrl #(
        .MAX_DIM (MAX_DIM),
        .DEPTH   (DEPTH),
        .ADDR_W  (ADDR_W)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .mode     (s_tuser),
        .row      (s_tdata[rsq_pkg::ROW_LSB    +: rsq_pkg::COORD_W]),
        .col      (s_tdata[rsq_pkg::COL_LSB    +: rsq_pkg::COORD_W]),
        .value    (s_tdata[rsq_pkg::VALUE_LSB  +: rsq_pkg::VAL_W]),
        .top      (s_tdata[rsq_pkg::TOP_LSB    +: rsq_pkg::COORD_W]),
        .left     (s_tdata[rsq_pkg::LEFT_LSB   +: rsq_pkg::COORD_W]),
        .bottom   (s_tdata[rsq_pkg::BOTTOM_LSB +: rsq_pkg::COORD_W]),
        .right    (s_tdata[rsq_pkg::RIGHT_LSB  +: rsq_pkg::COORD_W]),
        .out_full (out_full),
        .done     (done),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .acc_ctl  (acc_ctl)
    );

    rsq_cell_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rsq_accum u_accum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (acc_ctl),
        .add_data (rd_data),
        .acc      (acc)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (done) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            sum_reg <= acc;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = rsq_pkg::M_TDATA_W'(sum_reg);

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the rectangle sum query block over its stream ports.
module tb_top;

    localparam int GRID_DIM    = 64;
    localparam int IDX_W       = $clog2(GRID_DIM);
    localparam int STALL_LIMIT = 60000;
    localparam int MAX_SHOWN   = 10;
    localparam longint unsigned SUM_CAP = (64'd1 << rsq_pkg::SUM_W) - 64'd1;
    localparam rsq_pkg::val_t   VAL_TOP = '1;
    localparam rsq_pkg::coord_t EDGE_LO = rsq_pkg::coord_t'(1);
    localparam rsq_pkg::coord_t EDGE_HI = rsq_pkg::coord_t'(GRID_DIM);
    localparam rsq_pkg::coord_t PAST_HI = rsq_pkg::coord_t'(GRID_DIM + 1);
    localparam rsq_pkg::coord_t COORD_MAX = '1;

    typedef struct packed {
        rsq_pkg::coord_t right;
        rsq_pkg::coord_t bottom;
        rsq_pkg::coord_t left;
        rsq_pkg::coord_t top;
        rsq_pkg::val_t   value;
        rsq_pkg::coord_t col;
        rsq_pkg::coord_t row;
    } cell_req_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [rsq_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                          s_tuser  = rsq_pkg::MODE_LOAD;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [rsq_pkg::M_TDATA_W-1:0] m_tdata;

    rsq_pkg::val_t cell_mirror [GRID_DIM][GRID_DIM] = '{default: '0};
    rsq_pkg::sum_t pending_sums [$];
    int   send_idle_pct  = 0;
    int   rcv_idle_pct   = 0;
    int   mismatch_count = 0;
    int   stall_cycles   = 0;

    rectangle_sum_query #(
        .MAX_DIM(GRID_DIM)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic rsq_pkg::sum_t rect_total(rsq_pkg::coord_t t, rsq_pkg::coord_t l,
                                                 rsq_pkg::coord_t b, rsq_pkg::coord_t r);
        longint unsigned acc;
        int r0;
        int r1;
        int c0;
        int c1;
        acc = 0;
        if (t <= b && l <= r) begin
            r0 = (t < 1) ? 1 : int'(t);
            r1 = (b > GRID_DIM) ? GRID_DIM : int'(b);
            c0 = (l < 1) ? 1 : int'(l);
            c1 = (r > GRID_DIM) ? GRID_DIM : int'(r);
            for (int i = r0; i <= r1; i++) begin
                for (int j = c0; j <= c1; j++) begin
                    acc += cell_mirror[IDX_W'(i - 1)][IDX_W'(j - 1)];
                end
            end
        end
        if (acc > SUM_CAP) begin
            acc = SUM_CAP;
        end
        return rsq_pkg::sum_t'(acc);
    endfunction

    function automatic rsq_pkg::coord_t hot_coord();
        if ($urandom_range(99) < 70) begin
            return rsq_pkg::coord_t'($urandom_range(10, 1));
        end
        return rsq_pkg::coord_t'($urandom_range(GRID_DIM, 1));
    endfunction

    function automatic rsq_pkg::coord_t off_coord();
        if ($urandom_range(1) == 0) begin
            return '0;
        end
        return rsq_pkg::coord_t'($urandom_range(127, GRID_DIM + 1));
    endfunction

    task automatic send_beat(input logic mode, input cell_req_t req);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= req;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        if (mode == rsq_pkg::MODE_LOAD) begin
            if (req.row >= 1 && req.row <= GRID_DIM && req.col >= 1 && req.col <= GRID_DIM) begin
                cell_mirror[IDX_W'(req.row - 1)][IDX_W'(req.col - 1)] = req.value;
            end
        end else begin
            pending_sums.push_back(rect_total(req.top, req.left, req.bottom, req.right));
        end
    endtask

    task automatic load_cell(input rsq_pkg::coord_t row, input rsq_pkg::coord_t col,
                             input rsq_pkg::val_t value);
        cell_req_t req;
        req       = '0;
        req.row   = row;
        req.col   = col;
        req.value = value;
        send_beat(rsq_pkg::MODE_LOAD, req);
    endtask

    task automatic query_rect(input rsq_pkg::coord_t t, input rsq_pkg::coord_t l,
                              input rsq_pkg::coord_t b, input rsq_pkg::coord_t r);
        cell_req_t req;
        req        = '0;
        req.top    = t;
        req.left   = l;
        req.bottom = b;
        req.right  = r;
        send_beat(rsq_pkg::MODE_QUERY, req);
    endtask

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_sums.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic send_random_beat();
        logic [95:0] noise;
        cell_req_t   req;
        int          pick;
        noise = {$urandom(), $urandom(), $urandom()};
        req   = noise[rsq_pkg::S_TDATA_W-1:0];
        pick  = $urandom_range(99);
        if (pick < 50) begin
            req.row = hot_coord();
            req.col = hot_coord();
            send_beat(rsq_pkg::MODE_LOAD, req);
        end else if (pick < 58) begin
            if ($urandom_range(1) == 0) begin
                req.row = off_coord();
            end else begin
                req.col = off_coord();
            end
            send_beat(rsq_pkg::MODE_LOAD, req);
        end else if (pick < 88) begin
            req.top    = hot_coord();
            req.left   = hot_coord();
            req.bottom = req.top + rsq_pkg::coord_t'($urandom_range(7));
            req.right  = req.left + rsq_pkg::coord_t'($urandom_range(7));
            send_beat(rsq_pkg::MODE_QUERY, req);
        end else if (pick < 97) begin
            send_beat(rsq_pkg::MODE_QUERY, req);
        end else begin
            req.top    = EDGE_LO;
            req.left   = EDGE_LO;
            req.bottom = EDGE_HI;
            req.right  = EDGE_HI;
            send_beat(rsq_pkg::MODE_QUERY, req);
        end
    endtask

    task automatic test_grid_edges();
        cell_req_t junk;
        send_idle_pct = 38;
        rcv_idle_pct  = 68;
        load_cell(EDGE_LO, EDGE_LO, VAL_TOP);
        load_cell(EDGE_LO, EDGE_HI, VAL_TOP);
        load_cell(EDGE_HI, EDGE_LO, VAL_TOP);
        load_cell(EDGE_HI, EDGE_HI, VAL_TOP);
        load_cell(7'd32, 7'd33, 30'd12345);
        // drop out-of-grid loads
        load_cell(7'd0, 7'd5, VAL_TOP);
        load_cell(7'd5, 7'd0, VAL_TOP);
        load_cell(PAST_HI, 7'd3, VAL_TOP);
        load_cell(COORD_MAX, COORD_MAX, VAL_TOP);
        query_rect(EDGE_LO, EDGE_LO, EDGE_HI, EDGE_HI);
        query_rect(7'd0, 7'd0, COORD_MAX, COORD_MAX);
        query_rect(7'd10, EDGE_LO, 7'd9, EDGE_HI);
        query_rect(EDGE_LO, 7'd10, EDGE_HI, 7'd9);
        query_rect(EDGE_HI, EDGE_HI, EDGE_HI, EDGE_HI);
        query_rect(7'd0, 7'd0, 7'd0, 7'd0);
        query_rect(PAST_HI, PAST_HI, COORD_MAX, COORD_MAX);
        query_rect(EDGE_LO, EDGE_LO, EDGE_LO, EDGE_HI);
        load_cell(EDGE_HI, EDGE_HI, '0);
        query_rect(7'd32, 7'd33, EDGE_HI, EDGE_HI);
        junk        = '1;
        junk.top    = EDGE_LO;
        junk.left   = EDGE_LO;
        junk.bottom = EDGE_LO;
        junk.right  = EDGE_LO;
        send_beat(rsq_pkg::MODE_QUERY, junk);
        junk       = '1;
        junk.row   = 7'd2;
        junk.col   = 7'd2;
        send_beat(rsq_pkg::MODE_LOAD, junk);
        query_rect(7'd2, 7'd2, 7'd2, 7'd2);
        wait_results_done();
    endtask

    task automatic run_mixed_traffic(input int count);
        for (int n = 0; n < count; n++) begin
            send_random_beat();
        end
        wait_results_done();
    endtask

    task automatic test_receiver_backpressure();
        send_idle_pct = 38;
        rcv_idle_pct  = 68;
        run_mixed_traffic(40);
    endtask

    task automatic test_sender_gaps();
        send_idle_pct = 68;
        rcv_idle_pct  = 38;
        run_mixed_traffic(40);
    endtask

    task automatic test_full_throughput();
        send_idle_pct = 0;
        rcv_idle_pct  = 0;
        run_mixed_traffic(40);
    endtask

    task automatic note_mismatch(input string what, input rsq_pkg::sum_t want,
                                 input rsq_pkg::sum_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN) begin
            $display("rect_sum %s: expected %0d, got %0d", what, want, got);
        end
    endtask

    always @(posedge aclk) begin : result_check
        rsq_pkg::sum_t want;
        rsq_pkg::sum_t got;
        m_tready <= ($urandom_range(99) >= rcv_idle_pct);
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[rsq_pkg::SUM_W-1:0];
            if (pending_sums.size() == 0) begin
                note_mismatch("unexpected beat", '0, got);
            end else begin
                want = pending_sums.pop_front();
                if (got !== want) begin
                    note_mismatch("mismatch", want, got);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("rectangle_sum_query test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_grid_edges();
        test_receiver_backpressure();
        test_sender_gaps();
        test_full_throughput();
        repeat (GRID_DIM * GRID_DIM + 8) @(posedge aclk);
        if (mismatch_count == 0 && pending_sums.size() == 0) begin
            $display("rectangle_sum_query test passed");
        end else begin
            $display("rectangle_sum_query test failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/rsq_pkg.sv
rtl/rsq_cell_mem.sv
rtl/rsq_accum.sv
rtl/rsq_ctrl.sv
rtl/rectangle_sum_query.sv
tb/tb_top.sv
